/* hw/rtl/truecolor_pixel_packer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the truecolor pixel packer
// Concurrent checks used by the top level of the block.
// ----------------------------------------------------------------------------
`ifndef TRUECOLOR_PIXEL_PACKER_ASSERT_SVH
`define TRUECOLOR_PIXEL_PACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("truecolor_pixel_packer: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("truecolor_pixel_packer: assertion failed");

`endif

/* hw/rtl/tpp_pkg.sv */
// ----------------------------------------------------------------------------
// tpp_pkg
// Types, constants and helper functions of the truecolor pixel packer.
// ----------------------------------------------------------------------------
package tpp_pkg;

  localparam int unsigned MaskW   = 32;
  localparam int unsigned PosW    = 5;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned ProdW   = 40;
  localparam int unsigned SumW    = 11;
  localparam int unsigned CntW    = 2;
  localparam int unsigned IndexW  = 3;
  localparam int unsigned Round   = 127;
  localparam int unsigned Den     = 255;
  localparam int unsigned MaxCarry = 5;

  typedef enum logic [IndexW-1:0] {
    REG_RED_MASK   = 3'd0,
    REG_GREEN_MASK = 3'd1,
    REG_BLUE_MASK  = 3'd2,
    REG_BYTES      = 3'd3,
    REG_LOW_FIRST  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [MaskW-1:0] m;
    logic [PosW-1:0]  pos;
  } field_t;

  typedef struct packed {
    field_t            red;
    field_t            green;
    field_t            blue;
    logic [CntW-1:0]   last_idx;
    logic              low_first;
  } cfg_t;

  // Splits a mask into its lowest set bit position and the mask moved down.
  function automatic field_t split_mask(logic [MaskW-1:0] w);
    logic [MaskW-1:0] low;
    field_t           f;
    low = w & (~w + MaskW'(1));
    f.pos = '0;
    for (int i = 0; i < MaskW; i++) begin
      if (low[i]) f.pos = PosW'(i);
    end
    f.m = w >> f.pos;
    return f;
  endfunction

  // Quotient by 255 of a small digit sum.
  function automatic logic [2:0] div_small(logic [SumW-1:0] s);
    logic [2:0] r;
    r = '0;
    for (int k = 1; k <= MaxCarry; k++) begin
      if (s >= SumW'(Den * k)) r = r + 3'd1;
    end
    return r;
  endfunction

  // Clamps a byte count to 2..4 and returns the index of the last byte.
  function automatic logic [CntW-1:0] last_index(logic [IndexW-1:0] n);
    logic [CntW-1:0] r;
    if (n <= 3'd2) r = 2'd1;
    else if (n >= 3'd4) r = 2'd3;
    else r = 2'd2;
    return r;
  endfunction

endpackage

/* hw/rtl/truecolor_pixel_packer.sv */
// ----------------------------------------------------------------------------
// truecolor_pixel_packer
// Converts 24-bit RGB pixels into masked truecolour pixels sent byte by byte.
// ----------------------------------------------------------------------------
// Each pixel passes through a four-stage pipeline (multiply, byte sums,
// quotient and shift, field merge) and then a serialiser that sends it as
// two, three or four byte items, the last one marked. The pipeline takes a
// new pixel in every cycle unless pixel_stall is high, so the sustained rate
// is set by the byte-wide output alone. A configuration write takes effect
// in the following cycle.
module truecolor_pixel_packer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tpp_pkg::IndexW-1:0]   cfg_index,
  input  logic [tpp_pkg::MaskW-1:0]    cfg_data,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  input  logic [3*tpp_pkg::ChanW-1:0]  source_rgb,
  output logic                         byte_valid,
  input  logic                         byte_stall,
  output logic [tpp_pkg::ChanW-1:0]    out_byte,
  output logic                         last_byte
);
  import tpp_pkg::*;

  cfg_t             cfg;
  logic             word_valid;
  logic             word_ready;
  logic [MaskW-1:0] word;

  tpp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpp_pipe u_pipe (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .source_rgb  (source_rgb),
    .cfg         (cfg),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .word        (word)
  );

  tpp_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .last_idx   (cfg.last_idx),
    .low_first  (cfg.low_first),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_byte   (out_byte),
    .last_byte  (last_byte)
  );

`include "truecolor_pixel_packer_assert.svh"

  `TPP_ASSERT_IMPL(a_idle_no_stall, clk, rst, !byte_valid, !pixel_stall)
  `TPP_ASSERT_NEXT(a_pixel_continues, clk, rst, byte_valid && !byte_stall && !last_byte, byte_valid)
  `TPP_ASSERT_NEXT(a_word_held, clk, rst, word_valid && !word_ready, word_valid && $stable(word))

endmodule

/* hw/rtl/tpp_cfg.sv */
// ----------------------------------------------------------------------------
// tpp_cfg
// Configuration registers, kept as decoded field positions and last byte index.
// ----------------------------------------------------------------------------
module tpp_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tpp_pkg::IndexW-1:0]   cfg_index,
  input  logic [tpp_pkg::MaskW-1:0]    cfg_data,
  output tpp_pkg::cfg_t                cfg
);
  import tpp_pkg::*;

  field_t split;

  assign cfg_ready = 1'b1;
  assign split     = split_mask(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red.m       <= MaskW'(32'h0000_00FF);
      cfg.red.pos     <= PosW'(16);
      cfg.green.m     <= MaskW'(32'h0000_00FF);
      cfg.green.pos   <= PosW'(8);
      cfg.blue.m      <= MaskW'(32'h0000_00FF);
      cfg.blue.pos    <= PosW'(0);
      cfg.last_idx    <= CntW'(3);
      cfg.low_first   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_RED_MASK:   cfg.red   <= split;
        REG_GREEN_MASK: cfg.green <= split;
        REG_BLUE_MASK:  cfg.blue  <= split;
        REG_BYTES:      cfg.last_idx  <= last_index(cfg_data[IndexW-1:0]);
        REG_LOW_FIRST:  cfg.low_first <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/tpp_scale.sv */
// ----------------------------------------------------------------------------
// tpp_scale
// Three-stage datapath that scales one channel into its field.
// ----------------------------------------------------------------------------
module tpp_scale (
  input  logic                        clk,
  input  logic [2:0]                  en,
  input  logic [tpp_pkg::ChanW-1:0]   value,
  input  tpp_pkg::field_t             fld,
  output logic [tpp_pkg::MaskW-1:0]   field_val
);
  import tpp_pkg::*;

  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] prod_r;
  logic [MaskW:0]   hi_sum;
  logic [MaskW:0]   hi_sum_r;
  logic [16:0]      lo_sum;
  logic [16:0]      lo_sum_r;
  logic [SumW-1:0]  dsum;
  logic [SumW-1:0]  dsum_r;
  logic [MaskW-1:0] quot;

  // The quotient by 255 is the sum of the product moved down by whole bytes,
  // plus the small quotient of the sum of its bytes.
  assign prod   = ProdW'(value) * ProdW'(fld.m) + ProdW'(Round);
  assign hi_sum = (MaskW+1)'(prod_r[39:8]) + (MaskW+1)'(prod_r[39:16]);
  assign lo_sum = 17'(prod_r[39:24]) + 17'(prod_r[39:32]);
  assign dsum   = SumW'(prod_r[7:0]) + SumW'(prod_r[15:8]) + SumW'(prod_r[23:16])
                + SumW'(prod_r[31:24]) + SumW'(prod_r[39:32]);
  assign quot   = hi_sum_r[MaskW-1:0] + MaskW'(lo_sum_r) + MaskW'(div_small(dsum_r));

  always_ff @(posedge clk) begin
    if (en[0]) prod_r <= prod;
    if (en[1]) begin
      hi_sum_r <= hi_sum;
      lo_sum_r <= lo_sum;
      dsum_r   <= dsum;
    end
    if (en[2]) field_val <= quot << fld.pos;
  end

endmodule

/* hw/rtl/tpp_pipe.sv */
// ----------------------------------------------------------------------------
// tpp_pipe
// Four-stage pixel pipeline: three channel datapaths and the field merge.
// ----------------------------------------------------------------------------
module tpp_pipe (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  input  logic [3*tpp_pkg::ChanW-1:0]  source_rgb,
  input  tpp_pkg::cfg_t                cfg,
  output logic                         word_valid,
  input  logic                         word_ready,
  output logic [tpp_pkg::MaskW-1:0]    word
);
  import tpp_pkg::*;

  logic [3:0]       vld;
  logic [3:0]       rdy;
  logic [MaskW-1:0] red_f;
  logic [MaskW-1:0] green_f;
  logic [MaskW-1:0] blue_f;

  assign rdy[3] = !vld[3] || word_ready;
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];

  assign pixel_stall = !rdy[0];
  assign word_valid  = vld[3];

  tpp_scale u_red (
    .clk       (clk),
    .en        (rdy[2:0]),
    .value     (source_rgb[23:16]),
    .fld       (cfg.red),
    .field_val (red_f)
  );

  tpp_scale u_green (
    .clk       (clk),
    .en        (rdy[2:0]),
    .value     (source_rgb[15:8]),
    .fld       (cfg.green),
    .field_val (green_f)
  );

  tpp_scale u_blue (
    .clk       (clk),
    .en        (rdy[2:0]),
    .value     (source_rgb[7:0]),
    .fld       (cfg.blue),
    .field_val (blue_f)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= pixel_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) word <= red_f | green_f | blue_f;
  end

endmodule

/* hw/rtl/tpp_ser.sv */
// ----------------------------------------------------------------------------
// tpp_ser
// Byte serialiser that sends each pixel word as two to four items.
// ----------------------------------------------------------------------------
module tpp_ser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tpp_pkg::CntW-1:0]    last_idx,
  input  logic                        low_first,
  input  logic                        word_valid,
  output logic                        word_ready,
  input  logic [tpp_pkg::MaskW-1:0]   word,
  output logic                        byte_valid,
  input  logic                        byte_stall,
  output logic [tpp_pkg::ChanW-1:0]   out_byte,
  output logic                        last_byte
);
  import tpp_pkg::*;

  logic             busy;
  logic [CntW-1:0]  cnt;
  logic [MaskW-1:0] held;
  logic [CntW-1:0]  sel;
  logic             take;

  assign take       = busy && !byte_stall;
  assign last_byte  = (cnt == last_idx);
  assign word_ready = !busy || (take && last_byte);
  assign byte_valid = busy;
  assign sel        = low_first ? cnt : last_idx - cnt;
  assign out_byte   = held[{sel, 3'b000} +: ChanW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (word_ready) begin
      busy <= word_valid;
      cnt  <= '0;
    end else if (take) begin
      cnt  <= cnt + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (word_ready && word_valid) held <= word;
  end

endmodule
